// ----- rtl/rpt_pkg.sv -----
// Shared types and constants for the random point in tetrahedron block.
// Holds the request and response payloads, the controller command and status
// structs, and the generator constants. Depends on nothing.
package rpt_pkg;

   // Coordinate and weight formats
   localparam int COORD_WIDTH  = 32;
   localparam int FRAC_BITS    = 16;
   localparam int WEIGHT_BITS  = 24;
   localparam int WEIGHT_WIDTH = WEIGHT_BITS + 1;   // holds 0 .. ONE
   localparam int SUM_WIDTH    = WEIGHT_BITS + 2;   // sums of up to three weights
   localparam int PROD_WIDTH   = WEIGHT_WIDTH + 1 + COORD_WIDTH;
   localparam int ACC_WIDTH    = PROD_WIDTH + 2;    // four products

   localparam logic [SUM_WIDTH-1:0] WEIGHT_ONE = {2'b01, {WEIGHT_BITS{1'b0}}};

   // 48-bit linear congruential generator
   localparam int STATE_WIDTH = 48;
   localparam int HALF_WIDTH  = 16;
   localparam logic [31:0]            LCG_MUL_LO = 32'hDEEC_E66D;
   localparam logic [HALF_WIDTH-1:0]  LCG_MUL_HI = 16'h0005;
   localparam logic [STATE_WIDTH-1:0] LCG_ADD    = 48'h0000_0000_000B;
   localparam logic [STATE_WIDTH-1:0] SEED_RESET = 48'h1234_ABCD_370E;

   // Which fraction a draw fills
   localparam logic [1:0] SEL_S = 2'd0;
   localparam logic [1:0] SEL_T = 2'd1;
   localparam logic [1:0] SEL_U = 2'd2;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] v0_x;
      logic signed [COORD_WIDTH-1:0] v0_y;
      logic signed [COORD_WIDTH-1:0] v0_z;
      logic signed [COORD_WIDTH-1:0] v1_x;
      logic signed [COORD_WIDTH-1:0] v1_y;
      logic signed [COORD_WIDTH-1:0] v1_z;
      logic signed [COORD_WIDTH-1:0] v2_x;
      logic signed [COORD_WIDTH-1:0] v2_y;
      logic signed [COORD_WIDTH-1:0] v2_z;
      logic signed [COORD_WIDTH-1:0] v3_x;
      logic signed [COORD_WIDTH-1:0] v3_y;
      logic signed [COORD_WIDTH-1:0] v3_z;
   } rpt_req_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] point_x;
      logic signed [COORD_WIDTH-1:0] point_y;
      logic signed [COORD_WIDTH-1:0] point_z;
   } rpt_rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic       load_req;
      logic       draw_en;
      logic [1:0] draw_sel;
      logic       fold_prism;
      logic       fold_tet;
      logic       mac_en;
      logic [1:0] mac_sel;
      logic       out_load;
   } rpt_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic out_free;
   } rpt_status_type;

endpackage

// ----- rtl/random_point_in_tetrahedron_top.sv -----
// Top level of the random point in tetrahedron block.
// Joins the controller and the datapath. Depends on rpt_pkg, rpt_ctrl and
// rpt_datapath.
//
// Usage:
//   A request carries four vertices in signed Q16.16. It is taken when
//   req_valid is high and req_stall low. The block draws three fractions from
//   its 48-bit generator, folds them into barycentric weights and returns one
//   point on the rsp_ channel, taken when rsp_valid is high and rsp_stall low.
//   The controller sequence runs three generator steps, two fold steps and four
//   multiply-accumulate steps over the vertices (three lanes, one per axis),
//   then loads the output register; a new request is taken only once the
//   controller is back in idle.
//   A finished point waits in the output register while the next request is
//   taken; if it is still stalled when the next point is ready, the
//   controller holds until the output register is free.
//   csr_write_enable loads the generator state from csr_write_data; write it
//   only while the block is idle.
//   Reset (synchronous, active high) empties the output and loads the
//   generator with its default seed.
module random_point_in_tetrahedron_top
   import rpt_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  rpt_req_type            req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rpt_rsp_type            rsp_data,
   input  logic                   csr_write_enable,
   input  logic [STATE_WIDTH-1:0] csr_write_data
);

   rpt_cmd_type    cmd;
   rpt_status_type status;

   rpt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   rpt_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_data         (req_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data)
   );

endmodule

// ----- rtl/rpt_datapath.sv -----
// Datapath of the random point in tetrahedron block: generator, weight fold,
// three coordinate multiply-accumulate lanes and the response register.
// Depends on rpt_pkg.
module rpt_datapath
   import rpt_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  rpt_cmd_type    cmd,
   output rpt_status_type status,
   input  rpt_req_type    req_data,
   input  logic           csr_write_enable,
   input  logic [STATE_WIDTH-1:0] csr_write_data,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output rpt_rsp_type    rsp_data
);

   logic [STATE_WIDTH-1:0]  gen_ff, gen_in;
   rpt_req_type             vert_ff;
   logic [WEIGHT_WIDTH-1:0] s_ff, s_in, t_ff, t_in, u_ff, u_in, a_ff, a_in;
   logic signed [ACC_WIDTH-1:0] acc_x_ff, acc_x_in, acc_y_ff, acc_y_in;
   logic signed [ACC_WIDTH-1:0] acc_z_ff, acc_z_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rpt_rsp_type             rsp_ff, rsp_in;

   // Generator step: lower 32x32 product plus the 16-bit cross terms
   logic [63:0]             prod_ll;
   logic [HALF_WIDTH-1:0]   mul_cross;
   logic [STATE_WIDTH-1:0]  gen_next;

   always_comb begin
      prod_ll   = gen_ff[31:0] * LCG_MUL_LO;
      mul_cross = gen_ff[STATE_WIDTH-1:32] * LCG_MUL_LO[HALF_WIDTH-1:0]
                + gen_ff[HALF_WIDTH-1:0] * LCG_MUL_HI;
      gen_next  = prod_ll[STATE_WIDTH-1:0] + {mul_cross, 32'd0} + LCG_ADD;
   end

   always_comb begin
      gen_in = gen_ff;
      if (csr_write_enable) begin
         gen_in = csr_write_data;
      end else if (cmd.draw_en) begin
         gen_in = gen_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gen_ff <= SEED_RESET;
      end else begin
         gen_ff <= gen_in;
      end
   end

   // Vertex capture
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         vert_ff <= req_data;
      end
   end

   // Draws, then the prism fold, then the tetrahedron fold
   logic [WEIGHT_WIDTH-1:0] frac;
   logic [SUM_WIDTH-1:0]    s_w, t_w, u_w, st_sum, tu_sum, stu_sum;

   always_comb begin
      frac    = {1'b0, gen_next[STATE_WIDTH-1 -: WEIGHT_BITS]};
      s_w     = {1'b0, s_ff};
      t_w     = {1'b0, t_ff};
      u_w     = {1'b0, u_ff};
      st_sum  = s_w + t_w;
      tu_sum  = t_w + u_w;
      stu_sum = st_sum + u_w;
      s_in = s_ff;
      t_in = t_ff;
      u_in = u_ff;
      a_in = a_ff;
      if (cmd.draw_en) begin
         case (cmd.draw_sel)
            SEL_S:   s_in = frac;
            SEL_T:   t_in = frac;
            SEL_U:   u_in = frac;
            default: u_in = frac;
         endcase
      end else if (cmd.fold_prism) begin
         if (st_sum > WEIGHT_ONE) begin
            s_in = WEIGHT_WIDTH'(WEIGHT_ONE - s_w);
            t_in = WEIGHT_WIDTH'(WEIGHT_ONE - t_w);
         end
      end else if (cmd.fold_tet) begin
         if (tu_sum > WEIGHT_ONE) begin
            t_in = WEIGHT_WIDTH'(WEIGHT_ONE - u_w);
            u_in = WEIGHT_WIDTH'(WEIGHT_ONE - st_sum);
            a_in = WEIGHT_WIDTH'(tu_sum - WEIGHT_ONE);
         end else if (stu_sum > WEIGHT_ONE) begin
            s_in = WEIGHT_WIDTH'(WEIGHT_ONE - tu_sum);
            u_in = WEIGHT_WIDTH'(stu_sum - WEIGHT_ONE);
            a_in = WEIGHT_WIDTH'(WEIGHT_ONE - st_sum);
         end else begin
            a_in = WEIGHT_WIDTH'(WEIGHT_ONE - stu_sum);
         end
      end
   end

   always_ff @(posedge clock) begin
      s_ff <= s_in;
      t_ff <= t_in;
      u_ff <= u_in;
      a_ff <= a_in;
   end

   // Weight and vertex selection for this step of the accumulation
   logic signed [WEIGHT_WIDTH:0]    w_sel;
   logic signed [COORD_WIDTH-1:0]   cx, cy, cz;
   logic signed [PROD_WIDTH-1:0]    prod_x, prod_y, prod_z;

   always_comb begin
      case (cmd.mac_sel)
         2'd0: begin
            w_sel = {1'b0, a_ff};
            cx = vert_ff.v0_x; cy = vert_ff.v0_y; cz = vert_ff.v0_z;
         end
         2'd1: begin
            w_sel = {1'b0, s_ff};
            cx = vert_ff.v1_x; cy = vert_ff.v1_y; cz = vert_ff.v1_z;
         end
         2'd2: begin
            w_sel = {1'b0, t_ff};
            cx = vert_ff.v2_x; cy = vert_ff.v2_y; cz = vert_ff.v2_z;
         end
         default: begin
            w_sel = {1'b0, u_ff};
            cx = vert_ff.v3_x; cy = vert_ff.v3_y; cz = vert_ff.v3_z;
         end
      endcase
      prod_x = w_sel * cx;
      prod_y = w_sel * cy;
      prod_z = w_sel * cz;
   end

   // Three lanes; the first vertex restarts the sums
   always_comb begin
      acc_x_in = acc_x_ff;
      acc_y_in = acc_y_ff;
      acc_z_in = acc_z_ff;
      if (cmd.mac_en) begin
         if (cmd.mac_sel == 2'd0) begin
            acc_x_in = {{2{prod_x[PROD_WIDTH-1]}}, prod_x};
            acc_y_in = {{2{prod_y[PROD_WIDTH-1]}}, prod_y};
            acc_z_in = {{2{prod_z[PROD_WIDTH-1]}}, prod_z};
         end else begin
            acc_x_in = acc_x_ff + {{2{prod_x[PROD_WIDTH-1]}}, prod_x};
            acc_y_in = acc_y_ff + {{2{prod_y[PROD_WIDTH-1]}}, prod_y};
            acc_z_in = acc_z_ff + {{2{prod_z[PROD_WIDTH-1]}}, prod_z};
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_x_ff <= acc_x_in;
      acc_y_ff <= acc_y_in;
      acc_z_ff <= acc_z_in;
   end

   // Response register; the slice is floor division by ONE
   always_comb begin
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_in.point_x = acc_x_ff[WEIGHT_BITS +: COORD_WIDTH];
         rsp_in.point_y = acc_y_ff[WEIGHT_BITS +: COORD_WIDTH];
         rsp_in.point_z = acc_z_ff[WEIGHT_BITS +: COORD_WIDTH];
         rsp_valid_in   = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign status.out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_ff;

`ifndef ASSERT_OFF
   // Folded weights always sum to exactly one
   assert property (@(posedge clock) disable iff (reset)
      cmd.fold_tet |=> ((SUM_WIDTH+1)'(a_ff) + (SUM_WIDTH+1)'(s_ff) + (SUM_WIDTH+1)'(t_ff)
                        + (SUM_WIDTH+1)'(u_ff)) == (SUM_WIDTH+1)'(WEIGHT_ONE))
      else $error("folded weights do not sum to one");

   // A loaded response is presented in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_valid_ff)
      else $error("response load lost");

   // Generator only moves on a draw or a seed write
   assert property (@(posedge clock) disable iff (reset)
      (!cmd.draw_en && !csr_write_enable) |=> $stable(gen_ff))
      else $error("generator state moved without a draw");
`endif

endmodule

// ----- rtl/rpt_ctrl.sv -----
// Controller of the random point in tetrahedron block: sequences the three
// draws, two fold steps, four accumulate steps and the response load.
// Depends on rpt_pkg.
module rpt_ctrl
   import rpt_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  rpt_status_type status,
   output rpt_cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_DRAW  = 3'd1;
   localparam logic [2:0] ST_PRISM = 3'd2;
   localparam logic [2:0] ST_TET   = 3'd3;
   localparam logic [2:0] ST_MAC   = 3'd4;
   localparam logic [2:0] ST_DONE  = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [1:0] count_ff, count_in;
   logic       accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      cmd      = '0;
      cmd.draw_sel = count_ff;
      cmd.mac_sel  = count_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.load_req = 1'b1;
               count_in = 2'd0;
               state_in = ST_DRAW;
            end
         end
         ST_DRAW: begin
            cmd.draw_en = 1'b1;
            if (count_ff == SEL_U) begin
               count_in = 2'd0;
               state_in = ST_PRISM;
            end else begin
               count_in = count_ff + 2'd1;
            end
         end
         ST_PRISM: begin
            cmd.fold_prism = 1'b1;
            state_in = ST_TET;
         end
         ST_TET: begin
            cmd.fold_tet = 1'b1;
            count_in = 2'd0;
            state_in = ST_MAC;
         end
         ST_MAC: begin
            cmd.mac_en = 1'b1;
            count_in = count_ff + 2'd1;
            if (count_ff == 2'd3) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= 2'd0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

`ifndef ASSERT_OFF
   // An accepted request starts with the first draw
   assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_DRAW && count_ff == 2'd0))
      else $error("accepted request did not start drawing");

   // The fourth vertex closes the accumulation
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MAC && count_ff == 2'd3) |=> state_ff == ST_DONE)
      else $error("accumulation did not finish after four vertices");

   // Response register is never overwritten while held
   assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> status.out_free)
      else $error("response loaded while output stalled");
`endif

endmodule
